// File: rtl/vcr_pkg.sv
// shared constants and types for the video chip register block
// register map offsets, request codes and sizes; no dependencies
package vcr_pkg;

    localparam int REG_COUNT  = 47;
    localparam int SPRITES    = 8;
    localparam int LINE_TICKS = 64;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 8;
    localparam int LINE_W  = 9;
    localparam int CYCLE_W = 6;

    localparam logic [ADDR_W-1:0] ADDR_CTRL1  = 6'h11;
    localparam logic [ADDR_W-1:0] ADDR_RASTER = 6'h12;
    localparam logic [ADDR_W-1:0] ADDR_IRQ    = 6'h19;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_EN = 6'h1A;

    localparam logic [DATA_W-1:0] IRQ_READ_OR  = 8'h70;
    localparam logic [DATA_W-1:0] IRQ_RASTER   = 8'h01;
    localparam logic [DATA_W-1:0] IRQ_SUMMARY  = 8'h80;
    localparam logic [DATA_W-1:0] OUT_OF_RANGE = 8'hFF;

    localparam logic [LINE_W-1:0] LINE_RESET = 9'd200;
    localparam logic [LINE_W-1:0] LPF_RESET  = 9'd312;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_t;

endpackage

// File: rtl/video_chip_registers_raster_irq.sv
// video chip register file with raster line counter and raster interrupt
// byte registers in a synchronous memory; uses vcr_pkg
//
// channel   dir  tdata bits (lowest first)                  extra
// s_axis    in   req_type[1:0] address[7:2] write_data[15:8]  -
// m_axis    out  read_data[7:0] irq_line[8] frame_done[9]     zero pad [15:10]
// cfg       in   lines_per_frame[8:0] on cfg_wdata            cfg_we strobe
//
// one item per clock while the output is not stalled; each result appears in the cycle after its input transfer
// the memory read port is registered, the result register holds a stalled result
// synchronous active-low reset; register memory contents read as zero until written
// a stalled result blocks new input only while m_tready is low
module video_chip_registers_raster_irq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // req_type, address, write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data, irq_line, frame_done, zero pad
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata  // lines_per_frame
);

    logic [vcr_pkg::DATA_W-1:0] reg_mem [vcr_pkg::REG_COUNT];
    logic [vcr_pkg::REG_COUNT-1:0] mem_vld_reg, mem_vld_next;

    logic [vcr_pkg::DATA_W-1:0]  mem_rdata_reg;
    logic                        mem_rvld_reg;
    logic [vcr_pkg::DATA_W-1:0]  rd_mask_reg, rd_mask_next;
    logic [vcr_pkg::DATA_W-1:0]  rd_or_reg, rd_or_next;
    logic                        done_reg, done_next;
    logic                        m_tvalid_reg;

    logic [vcr_pkg::DATA_W-1:0]  irq_reg, irq_next;
    logic                        irq_en_reg, irq_en_next;
    logic [vcr_pkg::LINE_W-1:0]  cmp_reg, cmp_next;
    logic [vcr_pkg::LINE_W-1:0]  line_reg, line_next;
    logic [vcr_pkg::CYCLE_W-1:0] cycle_reg, cycle_next;
    logic [vcr_pkg::LINE_W-1:0]  lpf_reg;

    vcr_pkg::req_t               req;
    logic [vcr_pkg::ADDR_W-1:0]  addr;
    logic [vcr_pkg::DATA_W-1:0]  wdata;
    logic                        accept;
    logic                        in_range;
    logic                        line_end;
    logic                        match;
    logic [vcr_pkg::LINE_W-1:0]  line_inc;
    logic                        mem_re;
    logic                        mem_we;
    logic [vcr_pkg::DATA_W-1:0]  mem_data;

    assign req      = vcr_pkg::req_t'(s_tdata[1:0]);
    assign addr     = s_tdata[7:2];
    assign wdata    = s_tdata[15:8];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_range = ({1'b0, addr} < 7'(vcr_pkg::REG_COUNT));
    assign line_end = ({1'b0, cycle_reg} == 7'(vcr_pkg::LINE_TICKS - 1));
    assign match    = (cmp_reg == line_reg);
    assign line_inc = line_reg + 9'd1;
    assign mem_re   = accept && (req == vcr_pkg::REQ_READ) && in_range;
    assign mem_we   = accept && (req == vcr_pkg::REQ_WRITE) && in_range;

    always_comb begin
        irq_next     = irq_reg;
        irq_en_next  = irq_en_reg;
        cmp_next     = cmp_reg;
        line_next    = line_reg;
        cycle_next   = cycle_reg;
        mem_vld_next = mem_vld_reg;
        rd_mask_next = '0;
        rd_or_next   = '0;
        done_next    = 1'b0;
        if (mem_we) begin
            mem_vld_next[addr] = 1'b1;
        end
        unique case (req)
            vcr_pkg::REQ_TICK: begin
                if (!line_end) begin
                    cycle_next = cycle_reg + 6'd1;
                end else begin
                    cycle_next = '0;
                    if (match) begin
                        irq_next = irq_next | vcr_pkg::IRQ_RASTER;
                        if (irq_en_reg) begin
                            irq_next = irq_next | vcr_pkg::IRQ_SUMMARY;
                        end
                    end
                    if (line_inc == lpf_reg || line_inc == '0) begin
                        line_next = '0;
                        done_next = 1'b1;
                    end else begin
                        line_next = line_inc;
                    end
                end
            end
            vcr_pkg::REQ_READ: begin
                if (!in_range) begin
                    rd_or_next = vcr_pkg::OUT_OF_RANGE;
                end else if (addr == vcr_pkg::ADDR_CTRL1) begin
                    rd_mask_next = 8'h7F;
                    rd_or_next   = {line_reg[8], 7'd0};
                end else if (addr == vcr_pkg::ADDR_RASTER) begin
                    rd_or_next = line_reg[7:0];
                end else if (addr == vcr_pkg::ADDR_IRQ) begin
                    rd_or_next = irq_reg | vcr_pkg::IRQ_READ_OR;
                end else begin
                    rd_mask_next = 8'hFF;
                end
            end
            vcr_pkg::REQ_WRITE: begin
                if (in_range) begin
                    if (addr == vcr_pkg::ADDR_CTRL1) begin
                        cmp_next = {wdata[7], cmp_reg[7:0]};
                    end else if (addr == vcr_pkg::ADDR_RASTER) begin
                        cmp_next = {cmp_reg[8], wdata};
                    end else if (addr == vcr_pkg::ADDR_IRQ) begin
                        irq_next = irq_reg & ~wdata;
                    end else if (addr == vcr_pkg::ADDR_IRQ_EN) begin
                        irq_en_next = wdata[0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // register memory, one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            reg_mem[addr[$clog2(vcr_pkg::REG_COUNT)-1:0]] <= wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= reg_mem[addr[$clog2(vcr_pkg::REG_COUNT)-1:0]];
            mem_rvld_reg  <= mem_vld_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            mem_vld_reg  <= '0;
            irq_reg      <= '0;
            irq_en_reg   <= 1'b0;
            cmp_reg      <= '0;
            line_reg     <= vcr_pkg::LINE_RESET;
            cycle_reg    <= '0;
            lpf_reg      <= vcr_pkg::LPF_RESET;
        end else begin
            if (cfg_we) begin
                lpf_reg <= cfg_wdata;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
                mem_vld_reg  <= mem_vld_next;
                irq_reg      <= irq_next;
                irq_en_reg   <= irq_en_next;
                cmp_reg      <= cmp_next;
                line_reg     <= line_next;
                cycle_reg    <= cycle_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_mask_reg <= rd_mask_next;
            rd_or_reg   <= rd_or_next;
            done_reg    <= done_next;
        end
    end

    assign mem_data = mem_rvld_reg ? mem_rdata_reg : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, done_reg, irq_reg[7], (mem_data & rd_mask_reg) | rd_or_reg};

`ifndef SYNTHESIS
    a_cycle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, cycle_reg} <= 7'(vcr_pkg::LINE_TICKS - 1))
        else $error("line cycle counter out of range");

    a_raster_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && req == vcr_pkg::REQ_TICK && line_end && match |=> irq_reg[0])
        else $error("raster match did not latch interrupt");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done_next |=> line_reg == '0)
        else $error("frame wrap did not clear raster line");

    a_done_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && done_reg |-> m_tdata[7:0] == '0)
        else $error("frame wrap result carries read data");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(rd_mask_reg)
            && $stable(irq_reg))
        else $error("stalled result changed");
`endif

endmodule
